// ----- rtl/csbfa_pkg.sv -----
// csbfa_pkg: types, constants and bit-reorder helpers for the can signal
// bit-field access block; no dependencies
package csbfa_pkg;

   localparam int FRAME_BYTES = 8;
   localparam int FRAME_W     = FRAME_BYTES * 8;
   localparam int SIG_W       = 32;
   localparam int POS_W       = 7;   // holds start_bit + bit_length and frame length in bits

   typedef enum logic {
      OP_READ  = 1'b0,
      OP_WRITE = 1'b1
   } opcode_type;

   typedef enum logic {
      ORDER_MOTOROLA = 1'b0,
      ORDER_INTEL    = 1'b1
   } order_type;

   typedef struct packed {
      logic [SIG_W-1:0]   write_value;
      logic [5:0]         bit_length;
      logic [5:0]         start_bit;
      logic [3:0]         frame_length;
      logic [FRAME_W-1:0] frame_in;
      order_type          byte_order;
      opcode_type         opcode;
   } req_type;

   typedef struct packed {
      logic [FRAME_W-1:0] frame_out;
      logic [SIG_W-1:0]   read_value;
   } rsp_type;

   // mirror the bits inside every byte, so that motorola positions run in plain order
   function automatic logic [FRAME_W-1:0] swap_bits_in_bytes(input logic [FRAME_W-1:0] d);
      logic [FRAME_W-1:0] r;
      r = '0;
      for (int k = 0; k < FRAME_BYTES; k++) begin
         for (int b = 0; b < 8; b++) begin
            r[8*k+b] = d[8*k+7-b];
         end
      end
      return r;
   endfunction

   function automatic logic [SIG_W-1:0] reverse_sig(input logic [SIG_W-1:0] d);
      logic [SIG_W-1:0] r;
      r = '0;
      for (int b = 0; b < SIG_W; b++) begin
         r[b] = d[SIG_W-1-b];
      end
      return r;
   endfunction

endpackage

// ----- rtl/csbfa_access.sv -----
// csbfa_access: combinational read or write of one signal in a frame
// depends on csbfa_pkg
module csbfa_access (
   input  csbfa_pkg::req_type req,
   output csbfa_pkg::rsp_type rsp
);
   import csbfa_pkg::*;

   logic [3:0]         flen_sat;
   logic [5:0]         blen_sat;
   logic [POS_W-1:0]   end_pos;
   logic [POS_W-1:0]   limit_pos;
   logic [POS_W-1:0]   stop_pos;
   logic [POS_W-1:0]   start_ext;
   logic [5:0]         nbits;
   logic [SIG_W:0]     mask_wide;
   logic [SIG_W-1:0]   mask_n;
   logic [FRAME_W-1:0] seq_frame;
   logic [FRAME_W-1:0] seq_shift;
   logic [SIG_W-1:0]   extract;
   logic [SIG_W-1:0]   read_val;
   logic [SIG_W-1:0]   ins_val;
   logic [FRAME_W-1:0] ins_mask;
   logic [FRAME_W-1:0] ins_bits;
   logic [FRAME_W-1:0] seq_new;
   logic               intel;

   assign intel    = (req.byte_order == ORDER_INTEL);
   assign flen_sat = (req.frame_length > 4'(FRAME_BYTES)) ? 4'(FRAME_BYTES) : req.frame_length;
   assign blen_sat = (req.bit_length > 6'(SIG_W)) ? 6'(SIG_W) : req.bit_length;

   // the walk covers positions start .. min(start+len, 8*flen)-1
   assign start_ext = POS_W'(req.start_bit);
   assign end_pos   = start_ext + POS_W'(blen_sat);
   assign limit_pos = {flen_sat, 3'b000};
   assign stop_pos  = (end_pos < limit_pos) ? end_pos : limit_pos;
   assign nbits     = (stop_pos > start_ext) ? 6'(stop_pos - start_ext) : 6'd0;

   assign mask_wide = ((SIG_W+1)'(1) << nbits) - (SIG_W+1)'(1);
   assign mask_n    = mask_wide[SIG_W-1:0];

   assign seq_frame = intel ? req.frame_in : swap_bits_in_bytes(req.frame_in);
   assign seq_shift = seq_frame >> req.start_bit;
   assign extract   = seq_shift[SIG_W-1:0] & mask_n;

   // motorola: first bit visited is the msb of the gathered bits
   assign read_val = intel ? extract : (reverse_sig(extract) >> (6'(SIG_W) - nbits));

   // motorola: visited positions take write_value bits blen-1 downward
   assign ins_val  = (intel ? req.write_value
                            : (reverse_sig(req.write_value) >> (6'(SIG_W) - blen_sat))) & mask_n;
   assign ins_mask = {{(FRAME_W-SIG_W){1'b0}}, mask_n} << req.start_bit;
   assign ins_bits = {{(FRAME_W-SIG_W){1'b0}}, ins_val} << req.start_bit;
   assign seq_new  = (seq_frame & ~ins_mask) | ins_bits;

   always_comb begin
      if (req.opcode == OP_WRITE) begin
         rsp.read_value = '0;
         rsp.frame_out  = intel ? seq_new : swap_bits_in_bytes(seq_new);
      end else begin
         rsp.read_value = read_val;
         rsp.frame_out  = req.frame_in;
      end
   end

endmodule

// ----- rtl/can_signal_bit_field_access_top.sv -----
// can_signal_bit_field_access_top: stream wrapper with input and result registers
// depends on csbfa_pkg and csbfa_access
//
//   channel | direction | tdata (low bit up)                                  | tuser
//   req     | in        | frame_in, frame_length, start_bit, bit_length,      | opcode, byte_order
//           |           | write_value (112 bits)                              |
//   rsp     | out       | read_value, frame_out (96 bits)                     | -
//
// one item per cycle sustained while rsp_tready stays high; input register, then result register,
// with the access logic between them
// synchronous active-high reset empties both registers
// a stalled result holds; the input register keeps taking items while the result moves on
module can_signal_bit_field_access_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [111:0] req_tdata,   // frame_in, frame_length, start_bit, bit_length, write_value
   input  logic [1:0]   req_tuser,   // opcode, byte_order
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [95:0]  rsp_tdata    // read_value, frame_out
);
   import csbfa_pkg::*;

   logic    s1_valid_ff, s1_valid_in;
   req_type s1_req_ff, s1_req_in;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_rsp_ff, out_rsp_in;
   rsp_type calc_rsp;
   logic    adv_out;
   logic    req_take;

   assign adv_out    = !out_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || adv_out;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      s1_req_in              = s1_req_ff;
      s1_req_in.opcode       = opcode_type'(req_tuser[0]);
      s1_req_in.byte_order   = order_type'(req_tuser[1]);
      s1_req_in.frame_in     = req_tdata[63:0];
      s1_req_in.frame_length = req_tdata[67:64];
      s1_req_in.start_bit    = req_tdata[73:68];
      s1_req_in.bit_length   = req_tdata[79:74];
      s1_req_in.write_value  = req_tdata[111:80];
      s1_valid_in            = req_take || (s1_valid_ff && !adv_out);
      out_valid_in           = adv_out ? s1_valid_ff : out_valid_ff;
      out_rsp_in             = calc_rsp;
   end

   csbfa_access u_access (
      .req (s1_req_ff),
      .rsp (calc_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
      if (req_take) begin
         s1_req_ff <= s1_req_in;
      end
      if (adv_out && s1_valid_ff) begin
         out_rsp_ff <= out_rsp_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_rsp_ff.frame_out, out_rsp_ff.read_value};

`ifndef SYNTHESIS
   a_ready_low_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (s1_valid_ff && out_valid_ff && !rsp_tready))
      else $error("input blocked while pipeline has room");

   a_item_moves_out: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && adv_out) |=> rsp_tvalid)
      else $error("item in input register did not reach the result register");

   a_empty_frame_read_zero: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && adv_out && s1_req_ff.opcode == OP_READ
       && s1_req_ff.frame_length == 4'd0) |=> (rsp_tdata[31:0] == 32'd0))
      else $error("read of empty frame gave nonzero value");

   a_write_zero_len_keeps_frame: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && adv_out && s1_req_ff.opcode == OP_WRITE
       && s1_req_ff.bit_length == 6'd0) |=> (rsp_tdata[95:32] == $past(s1_req_ff.frame_in)))
      else $error("zero-length write changed the frame");
`endif

endmodule
